[src/url_path_decode_and_check_unit_assert.svh]
// assertion macros for the decoder top module
// each takes a label, an antecedent and a consequent, sampled on i_clk
// and disabled while i_rst_n is low
`ifndef URL_PATH_DECODE_AND_CHECK_UNIT_ASSERT_SVH
`define URL_PATH_DECODE_AND_CHECK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// consequent holds in the same cycle as the antecedent
`define UDC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("udc assertion failed");

// consequent holds in the cycle after the antecedent
`define UDC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("udc assertion failed");

`else

`define UDC_ASSERT_IMP(label, ante, cons)
`define UDC_ASSERT_NXT(label, ante, cons)

`endif

`endif

[src/udc_pkg.sv]
package udc_pkg;

    // field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned NIB_W   = 4;

    // characters of interest
    localparam logic [BYTE_W-1:0] CH_PERCENT   = 8'h25;
    localparam logic [BYTE_W-1:0] CH_PLUS      = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_COLON     = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_DOT       = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;

    // reset value of the buffer size register
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 11'd512;

    // escape decoding phase
    typedef enum logic [1:0] {
        PH_OUT  = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } t_phase;

    // kind of the current path segment
    typedef enum logic [1:0] {
        SEG_EMPTY  = 2'd0,
        SEG_DOT    = 2'd1,
        SEG_DOTDOT = 2'd2,
        SEG_OTHER  = 2'd3
    } t_seg;

    // status codes
    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_ESCAPE = 2'd1,
        ERR_SIZE   = 2'd2,
        ERR_UNSAFE = 2'd3
    } t_err;

    // decoder state carried from item to item
    typedef struct packed {
        t_phase            phase;
        logic [NIB_W-1:0]  high;
        logic [LEN_W-1:0]  count;
        logic              seen;
        t_seg              seg;
        t_err              err;
    } t_state;

    // one result item
    typedef struct packed {
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              done_res;
        t_err              status;
    } t_res;

    // hex digit decode: valid flag and value
    typedef struct packed {
        logic             ok;
        logic [NIB_W-1:0] val;
    } t_hex;

    function automatic t_hex hex_digit(input logic [BYTE_W-1:0] c);
        t_hex h;
        h.ok  = 1'b0;
        h.val = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = NIB_W'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.ok  = 1'b1;
            h.val = NIB_W'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.ok  = 1'b1;
            h.val = NIB_W'(c - 8'h37);
        end
        return h;
    endfunction

endpackage

[src/url_path_decode_and_check_unit.sv]
// URL path decoder and checker. Takes one encoded path byte per item and
// returns exactly one result item per input item: the decoded byte when one
// completes, and on the final byte the status (0 ok, 1 bad or unfinished
// escape, 2 too long or decoded NUL, 3 unsafe path). Throughput is one item
// per clock while the result output is not stalled. The rate is set by the
// per-byte state update (escape phase, count, segment kind, latched error),
// which is combinational between the input register and the result register
// that offers the result. A result waiting on a stalled output blocks
// acceptance of the next item only while the input register is full. The
// buffer size register should only be written between strings or while no
// item is in flight; writes are always taken (ready is held high).
`include "url_path_decode_and_check_unit_assert.svh"

module url_path_decode_and_check_unit #(
    parameter int unsigned BUFFER_LIMIT = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [udc_pkg::BYTE_W-1:0]         i_in_byte,
    input  logic                               i_in_last,
    // result channel
    output logic                               o_res_valid,
    input  logic                               i_res_stall,
    output logic                               o_out_valid,
    output logic [udc_pkg::BYTE_W-1:0]         o_out_byte,
    output logic                               o_done_res,
    output logic [1:0]                         o_status,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [udc_pkg::LEN_W-1:0]          i_cfg_data
);

    // largest limit the 11-bit register can express under the parameter
    localparam int unsigned LEN_MAX = (1 << udc_pkg::LEN_W) - 1;
    localparam logic [udc_pkg::LEN_W-1:0] LIMIT_CAP =
        udc_pkg::LEN_W'((BUFFER_LIMIT > LEN_MAX) ? LEN_MAX : BUFFER_LIMIT);
    localparam logic [udc_pkg::LEN_W-1:0] LIMIT_RST =
        (udc_pkg::MAX_LENGTH_RST > LIMIT_CAP) ? LIMIT_CAP : udc_pkg::MAX_LENGTH_RST;

    logic                          r_in_valid;
    logic [udc_pkg::BYTE_W-1:0]    r_in_byte;
    logic                          r_in_last;
    logic                          r_res_valid;
    udc_pkg::t_res                 r_res;
    udc_pkg::t_state               r_state;
    logic [udc_pkg::LEN_W-1:0]     r_limit;

    udc_pkg::t_state               n_state;
    udc_pkg::t_res                 n_res;
    logic                          out_load;
    logic                          advance;
    logic                          in_accept;

    // handshake control
    assign out_load   = !r_res_valid || !i_res_stall;
    assign advance    = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // effective buffer limit, clamped at write time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
        end else if (i_cfg_valid) begin
            r_limit <= (i_cfg_data > LIMIT_CAP) ? LIMIT_CAP : i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    // per-byte decode and check
    udc_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_limit (r_limit),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (advance) begin
            r_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_out_valid = r_res.out_valid;
    assign o_out_byte  = r_res.out_byte;
    assign o_done_res  = r_res.done_res;
    assign o_status    = r_res.status;

    // the final byte returns the decoder to its start state
    `UDC_ASSERT_NXT(a_clear_after_last, advance && r_in_last, r_state == '0)

    // no decoded byte while a decoding error is latched
    `UDC_ASSERT_NXT(a_quiet_after_error,
        advance && !r_in_last && (r_state.err == udc_pkg::ERR_ESCAPE ||
        r_state.err == udc_pkg::ERR_SIZE), !o_out_valid)

    // a decoded byte is never a NUL
    `UDC_ASSERT_IMP(a_no_nul_out, r_res_valid && o_out_valid,
        o_out_byte != udc_pkg::CH_NUL)

    // an empty input register is never stalled
    `UDC_ASSERT_IMP(a_stall_only_full, o_in_stall, r_in_valid && r_res_valid)

endmodule

[src/udc_step.sv]
module udc_step (
    input  udc_pkg::t_state                    i_state,
    input  logic [udc_pkg::BYTE_W-1:0]         i_byte,
    input  logic                               i_last,
    input  logic [udc_pkg::LEN_W-1:0]          i_limit,
    output udc_pkg::t_state                    o_state,
    output udc_pkg::t_res                      o_res
);

    logic                          blocked;
    logic                          take;
    logic [udc_pkg::BYTE_W-1:0]    dec;
    udc_pkg::t_hex                 hex;
    logic [udc_pkg::LEN_W:0]       count_inc;
    logic                          accepted;
    udc_pkg::t_state               s;

    assign hex       = udc_pkg::hex_digit(i_byte);
    assign count_inc = {1'b0, i_state.count} + {{udc_pkg::LEN_W{1'b0}}, 1'b1};
    assign blocked   = (i_state.err == udc_pkg::ERR_ESCAPE) ||
                       (i_state.err == udc_pkg::ERR_SIZE);

    always_comb begin
        s        = i_state;
        take     = 1'b0;
        accepted = 1'b0;
        dec      = i_byte;

        // escape decoding
        if (!blocked) begin
            if (i_state.phase == udc_pkg::PH_OUT) begin
                if (i_byte == udc_pkg::CH_PERCENT) begin
                    s.phase = udc_pkg::PH_HIGH;
                end else begin
                    dec  = (i_byte == udc_pkg::CH_PLUS) ? udc_pkg::CH_SPACE : i_byte;
                    take = 1'b1;
                end
            end else if (!hex.ok) begin
                s.err   = udc_pkg::ERR_ESCAPE;
                s.phase = udc_pkg::PH_OUT;
            end else if (i_state.phase == udc_pkg::PH_HIGH) begin
                s.high  = hex.val;
                s.phase = udc_pkg::PH_LOW;
            end else begin
                dec     = {i_state.high, hex.val};
                s.phase = udc_pkg::PH_OUT;
                take    = 1'b1;
            end
        end

        // length, nul and path safety checks on a decoded byte
        if (take) begin
            if (dec == udc_pkg::CH_NUL || count_inc >= {1'b0, i_limit}) begin
                s.err = udc_pkg::ERR_SIZE;
            end else begin
                accepted = 1'b1;
                s.count  = count_inc[udc_pkg::LEN_W-1:0];
                if (!i_state.seen && dec != udc_pkg::CH_SLASH) begin
                    s.err = udc_pkg::ERR_UNSAFE;
                end
                s.seen = 1'b1;
                if (dec < udc_pkg::CH_SPACE || dec == udc_pkg::CH_BACKSLASH ||
                    dec == udc_pkg::CH_COLON) begin
                    s.err = udc_pkg::ERR_UNSAFE;
                end
                if (dec == udc_pkg::CH_SLASH) begin
                    if (i_state.seg == udc_pkg::SEG_DOTDOT) begin
                        s.err = udc_pkg::ERR_UNSAFE;
                    end
                    s.seg = udc_pkg::SEG_EMPTY;
                end else if (dec == udc_pkg::CH_DOT) begin
                    case (i_state.seg)
                        udc_pkg::SEG_EMPTY:  s.seg = udc_pkg::SEG_DOT;
                        udc_pkg::SEG_DOT:    s.seg = udc_pkg::SEG_DOTDOT;
                        default:             s.seg = udc_pkg::SEG_OTHER;
                    endcase
                end else begin
                    s.seg = udc_pkg::SEG_OTHER;
                end
            end
        end

        // end of string checks
        if (i_last) begin
            if (s.err != udc_pkg::ERR_ESCAPE && s.err != udc_pkg::ERR_SIZE) begin
                if (s.phase != udc_pkg::PH_OUT) begin
                    s.err = udc_pkg::ERR_ESCAPE;
                end else if (s.count == '0 || s.seg == udc_pkg::SEG_DOTDOT) begin
                    s.err = udc_pkg::ERR_UNSAFE;
                end
            end
        end

        // result item
        o_res.out_valid = accepted;
        o_res.out_byte  = accepted ? dec : '0;
        o_res.done_res  = i_last;
        o_res.status    = i_last ? s.err : udc_pkg::ERR_NONE;

        // back to the start state after the final byte
        o_state = i_last ? udc_pkg::t_state'('0) : s;
    end

endmodule
